// ===== hw/rtl/fsnr_pkg.sv =====
// ----------------------------------------------------------------------------
// fsnr_pkg
// Shared phase codes, parser state type and reset value for the
// format string %n rejector.
// ----------------------------------------------------------------------------
package fsnr_pkg;

  localparam int unsigned PhaseW = 5;

  // Parser phase codes
  localparam logic [PhaseW-1:0] PhText  = 5'd0;
  localparam logic [PhaseW-1:0] PhPct   = 5'd1;
  localparam logic [PhaseW-1:0] PhPos   = 5'd2;
  localparam logic [PhaseW-1:0] PhFlags = 5'd3;
  localparam logic [PhaseW-1:0] PhWdig  = 5'd4;
  localparam logic [PhaseW-1:0] PhWstar = 5'd5;
  localparam logic [PhaseW-1:0] PhPostw = 5'd6;
  localparam logic [PhaseW-1:0] PhDot   = 5'd7;
  localparam logic [PhaseW-1:0] PhPstar = 5'd8;
  localparam logic [PhaseW-1:0] PhPdig  = 5'd9;
  localparam logic [PhaseW-1:0] PhLen   = 5'd10;
  localparam logic [PhaseW-1:0] PhH     = 5'd11;
  localparam logic [PhaseW-1:0] PhL     = 5'd12;
  localparam logic [PhaseW-1:0] PhI     = 5'd13;
  localparam logic [PhaseW-1:0] PhI3    = 5'd14;
  localparam logic [PhaseW-1:0] PhI6    = 5'd15;
  localparam logic [PhaseW-1:0] PhConv  = 5'd16;

  // Longest chain of re-examinations of one byte (percent through conversion)
  localparam int unsigned StepMax = 6;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              all_zero;
    logic              seen;
    logic              rejected;
  } fsnr_state_t;

  localparam fsnr_state_t StateReset = '{
    phase:    PhText,
    all_zero: 1'b1,
    seen:     1'b0,
    rejected: 1'b0
  };

endpackage

// ===== hw/rtl/fsnr_if.sv =====
// ----------------------------------------------------------------------------
// fsnr_if
// Valid/ready channels of the rejector: byte input and verdict output.
// ----------------------------------------------------------------------------
interface fsnr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface fsnr_out_if;
  logic valid;
  logic ready;
  logic done_res;
  logic safe;

  modport source (output valid, output done_res, output safe, input ready);
  modport sink   (input valid, input done_res, input safe, output ready);
endinterface

// ===== hw/rtl/fsnr_parser.sv =====
// ----------------------------------------------------------------------------
// fsnr_parser
// Next-state logic of the conversion spec parser for one byte. A byte that
// closes one part of a spec is re-examined in the following phase.
// ----------------------------------------------------------------------------
module fsnr_parser
  import fsnr_pkg::*;
(
  input  logic [7:0]  ch_i,
  input  fsnr_state_t cur_i,
  output fsnr_state_t nxt_o
);

  always_comb begin
    fsnr_state_t st;
    logic        again;
    logic        dig;
    logic        flag;
    st    = cur_i;
    again = (ch_i != 8'd0);   // zero byte is not parsed
    dig   = ch_i inside {["0":"9"]};
    flag  = ch_i inside {"-", "+", " ", "#", "0", "'"};
    for (int unsigned k = 0; k < StepMax; k++) begin
      if (again) begin
        again = 1'b0;
        case (st.phase)
          PhPct: begin
            if (ch_i == "%") begin
              st.phase = PhText;
            end else begin
              st.phase    = PhPos;
              st.seen     = 1'b0;
              st.all_zero = 1'b1;
              again       = 1'b1;
            end
          end
          PhPos: begin
            if (dig) begin
              st.seen = 1'b1;
              if (ch_i != "0") st.all_zero = 1'b0;
            end else if (ch_i == "$") begin
              st.phase = PhFlags;
            end else begin
              // zero-only run acts as '0' flags, otherwise it was the width
              st.phase = (!st.seen || st.all_zero) ? PhFlags : PhPostw;
              again    = 1'b1;
            end
          end
          PhFlags: begin
            if (flag) begin
              st.phase = PhFlags;
            end else if (ch_i == "*") begin
              st.phase = PhWstar;
              st.seen  = 1'b0;
            end else if (dig) begin
              st.phase = PhWdig;
            end else begin
              st.phase = PhPostw;
              again    = 1'b1;
            end
          end
          PhWdig, PhPdig: begin
            if (!dig) begin
              st.phase = (st.phase == PhWdig) ? PhPostw : PhLen;
              again    = 1'b1;
            end
          end
          PhWstar, PhPstar: begin
            if (dig) begin
              st.seen = 1'b1;
            end else if (ch_i == "$") begin
              st.phase = (st.phase == PhWstar) ? PhPostw : PhLen;
            end else begin
              if (st.seen) st.phase = PhText;
              else         st.phase = (st.phase == PhWstar) ? PhPostw : PhLen;
              again = 1'b1;
            end
          end
          PhPostw: begin
            if (ch_i == ".") begin
              st.phase = PhDot;
            end else begin
              st.phase = PhLen;
              again    = 1'b1;
            end
          end
          PhDot: begin
            if (ch_i == "*") begin
              st.phase = PhPstar;
              st.seen  = 1'b0;
            end else if (dig) begin
              st.phase = PhPdig;
            end else begin
              st.phase = PhLen;
              again    = 1'b1;
            end
          end
          PhLen: begin
            if (ch_i == "h") begin
              st.phase = PhH;
            end else if (ch_i == "l") begin
              st.phase = PhL;
            end else if (ch_i == "I") begin
              st.phase = PhI;
            end else if (ch_i inside {"j", "z", "t", "L", "w"}) begin
              st.phase = PhConv;
            end else begin
              st.phase = PhConv;
              again    = 1'b1;
            end
          end
          PhH, PhL: begin
            again    = (ch_i != ((st.phase == PhH) ? "h" : "l"));
            st.phase = PhConv;
          end
          PhI: begin
            if (ch_i == "3") begin
              st.phase = PhI3;
            end else if (ch_i == "6") begin
              st.phase = PhI6;
            end else begin
              st.phase = PhText;
              again    = 1'b1;
            end
          end
          PhI3, PhI6: begin
            if (ch_i == ((st.phase == PhI3) ? "2" : "4")) begin
              st.phase = PhConv;
            end else begin
              st.phase = PhText;
              again    = 1'b1;
            end
          end
          PhConv: begin
            if (ch_i == "n") st.rejected = 1'b1;
            st.phase = PhText;
          end
          default: begin
            // plain text and unused codes
            st.phase = (ch_i == "%") ? PhPct : PhText;
          end
        endcase
      end
    end
    nxt_o = st;
  end

endmodule

// ===== hw/rtl/format_string_n_rejector_unit.sv =====
// ----------------------------------------------------------------------------
// format_string_n_rejector_unit
// Streaming printf format string scanner that flags any %n conversion.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one byte of the format string per item (ch, last). A zero byte or
//           an item with last set ends the string.
//   out_o : one result item per input item. done_res is 1 for the byte that
//           ended the string; safe is 0 once a %n conversion has been seen
//           in the current string, that byte included.
//   Path: an accepted byte waits in the input register; its result is
//           written to the result register when that register can take it.
//   Throughput: one item per cycle unless out_o stalls. The parser state is
//           the only loop; byte and state resolve in one pass of fsnr_parser.
//   Reset: rst_ni clears both registers' valid bits and puts the parser in
//           plain text with the reject flag clear.
//   Stall: while out_o is stalled the result holds; one more byte may still
//           be taken into the input register, then in_i.ready drops.
//   After a string ends all parser state, the reject flag too, is cleared.
// ----------------------------------------------------------------------------
module format_string_n_rejector_unit
  import fsnr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  fsnr_in_if.sink    in_i,
  fsnr_out_if.source out_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] ch_q;
  logic       last_q;

  // result register
  logic       out_valid_q;
  logic       done_q;
  logic       safe_q;

  // parser state
  fsnr_state_t st_q, st_d, st_step;

  logic adv;    // result register can take a new result
  logic fire;   // input register item is processed this cycle
  logic ends;   // processed byte ends the string

  assign adv  = !out_valid_q || out_o.ready;
  assign fire = in_valid_q && adv;
  assign ends = (ch_q == 8'd0) || last_q;

  // Input register refills when empty or when its item moves on.
  assign in_i.ready = !in_valid_q || adv;

  fsnr_parser u_parser (
    .ch_i  (ch_q),
    .cur_i (st_q),
    .nxt_o (st_step)
  );

  always_comb begin
    st_d = st_q;
    if (fire) st_d = ends ? StateReset : st_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= StateReset;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (adv)        out_valid_q <= in_valid_q;
      st_q <= st_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q   <= in_i.ch;
      last_q <= in_i.last;
    end
    if (fire) begin
      done_q <= ends;
      safe_q <= !st_step.rejected;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.done_res = done_q;
  assign out_o.safe     = safe_q;

`ifndef SYNTHESIS
  // A string end leaves the parser in plain text with no reject pending.
  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ends) |=> (st_q.phase == PhText && !st_q.rejected))
    else $error("parser state not reset after end of string");

  // An unsafe result mid-string means the reject flag is held.
  a_unsafe_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !safe_q && !done_q) |-> st_q.rejected)
    else $error("unsafe result without reject flag");

  // The reject flag only clears at a string end.
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.rejected && !(fire && ends)) |=> st_q.rejected)
    else $error("reject flag dropped mid-string");

  // State moves only when an item is processed.
  a_state_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(st_q))
    else $error("parser state changed without an item");
`endif

endmodule
